// ----- design/afsf_pkg.sv -----
// Shared types and constants for the absolute encoder frame spike filter.
`default_nettype none
package afsf_pkg;

	localparam int COUNT_W = 16;
	localparam int BYTE_W = 8;
	localparam int RATIO_W = 4;
	localparam int FILL_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int STEP_W = COUNT_W + 1;
	localparam int PROD_W = STEP_W + RATIO_W;

	localparam logic [FILL_W-1:0] FILL_COUNT = 3'd4;
	localparam logic [8:0] ALARM_MASK = 9'h1FF;
	localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 16'd100;
	localparam logic [RATIO_W-1:0] RATIO_RESET = 4'd4;

	typedef enum logic [1:0] {
		ST_VALID = 2'd0,
		ST_ALARM = 2'd1,
		ST_SPIKE = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_JUMP_THRESHOLD = 2'd0,
		REG_JUMP_RATIO = 2'd1
	} cfg_reg_t;

	// Magnitude of the wrapped two's-complement difference a - b.
	function automatic logic [STEP_W-1:0] step_mag(input logic [COUNT_W-1:0] a,
		input logic [COUNT_W-1:0] b);
		logic [COUNT_W-1:0] d;
		d = a - b;
		if (d[COUNT_W-1]) begin
			return {1'b0, ~d} + STEP_W'(1);
		end
		return {1'b0, d};
	endfunction

endpackage
`default_nettype wire

// ----- design/abs_encoder_frame_spike_filter.sv -----
// Top level of the absolute encoder frame spike filter.
// Takes one four-byte encoder frame per word and returns one result word per frame: the
// filtered 16-bit count, a status (valid, alarm frame rejected, spike replaced) and the
// initial position latched from the first good frame. A frame is registered on entry and
// the filter works on it from the input register, writing the result register and the
// history at the same edge, so a frame can be taken every cycle while the result word is
// not stalled. While a result waits under stall the input stage takes one more frame
// and then stalls the input until the result word is taken.
// Registers: index 0 sets the spike step threshold, index 1 the ratio to the previous step.
`default_nettype none
module abs_encoder_frame_spike_filter (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [afsf_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [afsf_pkg::COUNT_W-1:0]           cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic [afsf_pkg::BYTE_W-1:0]            frame_byte0,
	input  wire logic [afsf_pkg::BYTE_W-1:0]            frame_byte1,
	input  wire logic [afsf_pkg::BYTE_W-1:0]            frame_byte2,
	input  wire logic [afsf_pkg::BYTE_W-1:0]            frame_byte3,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic [afsf_pkg::COUNT_W-1:0]                position,
	output afsf_pkg::status_t                           status,
	output logic [afsf_pkg::COUNT_W-1:0]                initial_position,
	output logic                                        initial_valid
);
	import afsf_pkg::*;

	logic [COUNT_W-1:0] threshold_q;
	logic [RATIO_W-1:0] ratio_q;

	logic valid_s1;
	logic [BYTE_W-1:0] b0_s1, b1_s1, b2_s1, b3_s1;

	logic [COUNT_W-1:0] last_q, before_last_q, start_q;
	logic [FILL_W-1:0] fill_q;
	logic latched_q;

	logic out_valid_q;
	logic [COUNT_W-1:0] position_q, initial_position_q;
	status_t status_q;
	logic initial_valid_q;

	logic advance, fire;
	logic alarm;
	logic [COUNT_W-1:0] count, extrap, result;
	logic [STEP_W-1:0] step, prev;
	logic [PROD_W-1:0] bound;
	logic filled, spike;

	assign cfg_ready = 1'b1;
	assign advance = ~out_valid_q | ~out_stall;
	assign in_stall = valid_s1 & ~advance;
	assign fire = valid_s1 & advance;

	always_comb begin
		alarm = |({b2_s1[0], b3_s1} & ALARM_MASK);
		count = {b0_s1[6:0], b1_s1, b2_s1[7]};
		step = step_mag(count, last_q);
		prev = step_mag(last_q, before_last_q);
		bound = PROD_W'(ratio_q) * PROD_W'(prev);
		extrap = {last_q[COUNT_W-2:0], 1'b0} - before_last_q;
		filled = (fill_q >= FILL_COUNT);
		spike = filled & (PROD_W'(step) > bound) & (step > STEP_W'(threshold_q));
		result = spike ? extrap : count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			ratio_q <= RATIO_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_JUMP_THRESHOLD: threshold_q <= cfg_data;
				REG_JUMP_RATIO: ratio_q <= cfg_data[RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			b0_s1 <= frame_byte0;
			b1_s1 <= frame_byte1;
			b2_s1 <= frame_byte2;
			b3_s1 <= frame_byte3;
		end
	end

	// History and latched start position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			before_last_q <= '0;
			fill_q <= '0;
			start_q <= '0;
			latched_q <= 1'b0;
		end else if (fire && !alarm) begin
			last_q <= result;
			before_last_q <= last_q;
			if (!filled) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (!latched_q) begin
				start_q <= result;
				latched_q <= 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			initial_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				initial_valid_q <= latched_q | ~alarm;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			position_q <= alarm ? last_q : result;
			status_q <= alarm ? ST_ALARM : (spike ? ST_SPIKE : ST_VALID);
			initial_position_q <= (latched_q || alarm) ? start_q : result;
		end
	end

	assign out_valid = out_valid_q;
	assign position = position_q;
	assign status = status_q;
	assign initial_position = initial_position_q;
	assign initial_valid = initial_valid_q;

endmodule
`default_nettype wire

// ----- design/afsf_checker.sv -----
// Port-level checks for the absolute encoder frame spike filter, bound to the top level.
`default_nettype none
module afsf_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           out_valid,
	input wire logic                           out_stall,
	input wire logic [afsf_pkg::COUNT_W-1:0]   position,
	input wire afsf_pkg::status_t              status,
	input wire logic [afsf_pkg::COUNT_W-1:0]   initial_position,
	input wire logic                           initial_valid
);
	import afsf_pkg::*;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_VALID || status == ST_ALARM || status == ST_SPIKE))
		else $error("status word carries an undefined code");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position) && $stable(status))
		else $error("stalled result word changed");

	a_initial_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		initial_valid |=> initial_valid && $stable(initial_position))
		else $error("initial position changed after latching");

	a_alarm_before_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ALARM && !initial_valid |-> position == '0)
		else $error("alarm before any good frame must report zero position");

	a_spike_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_SPIKE |-> initial_valid)
		else $error("spike reported before initial position latched");

endmodule

bind abs_encoder_frame_spike_filter afsf_checker u_afsf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.position(position),
	.status(status),
	.initial_position(initial_position),
	.initial_valid(initial_valid)
);
`default_nettype wire

// ----- tb/afsf_frame_monitor.sv -----
// Watches the spike filter's channels, predicts each result word and compares it field by field.
module afsf_frame_monitor
	import afsf_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COUNT_W-1:0]   cfg_data,
	input  wire logic                 in_valid,
	input  wire logic                 in_stall,
	input  wire logic [BYTE_W-1:0]    frame_byte0,
	input  wire logic [BYTE_W-1:0]    frame_byte1,
	input  wire logic [BYTE_W-1:0]    frame_byte2,
	input  wire logic [BYTE_W-1:0]    frame_byte3,
	input  wire logic                 out_valid,
	input  wire logic                 out_stall,
	input  wire logic [COUNT_W-1:0]   position,
	input  wire status_t              status,
	input  wire logic [COUNT_W-1:0]   initial_position,
	input  wire logic                 initial_valid,
	output int                        errors,
	output int                        pending
);

	typedef struct packed {
		logic [COUNT_W-1:0] position;
		status_t            status;
		logic [COUNT_W-1:0] initial_position;
		logic               initial_valid;
	} filter_word_t;

	logic [COUNT_W-1:0] spike_threshold;
	logic [RATIO_W-1:0] spike_ratio;
	logic [COUNT_W-1:0] newest;
	logic [COUNT_W-1:0] older;
	logic [FILL_W-1:0]  fill_level;
	logic [COUNT_W-1:0] start_pos;
	logic               start_seen;
	filter_word_t       awaited_words[$];

	initial errors = 0;
	initial pending = 0;

	function automatic logic [STEP_W-1:0] wrapped_distance(input logic [COUNT_W-1:0] a,
		input logic [COUNT_W-1:0] b);
		logic [COUNT_W-1:0] d;
		d = a - b;
		if (d[COUNT_W-1]) begin
			return 17'h10000 - {1'b0, d};
		end
		return {1'b0, d};
	endfunction

	function automatic filter_word_t filter_frame(input logic [BYTE_W-1:0] b0,
		input logic [BYTE_W-1:0] b1, input logic [BYTE_W-1:0] b2,
		input logic [BYTE_W-1:0] b3);
		logic [COUNT_W-1:0] count;
		logic [COUNT_W-1:0] result;
		logic [STEP_W-1:0]  step;
		logic [STEP_W-1:0]  prev;
		logic [PROD_W-1:0]  bound;
		status_t            st;
		st = ST_VALID;
		if ({b2[0], b3} == 9'd0) begin
			count = {b0[6:0], b1, b2[7]};
			result = count;
			if (fill_level < FILL_COUNT) begin
				fill_level = fill_level + 1'b1;
			end else begin
				step = wrapped_distance(count, newest);
				prev = wrapped_distance(newest, older);
				bound = spike_ratio * prev;
				if (step > bound && step > spike_threshold) begin
					result = (newest << 1) - older;
					st = ST_SPIKE;
				end
			end
			older = newest;
			newest = result;
			if (!start_seen) begin
				start_pos = result;
				start_seen = 1'b1;
			end
		end else begin
			st = ST_ALARM;
		end
		return '{newest, st, start_pos, start_seen};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		filter_word_t want;
		if (!arst_n) begin
			spike_threshold = THRESHOLD_RESET;
			spike_ratio = RATIO_RESET;
			newest = '0;
			older = '0;
			fill_level = '0;
			start_pos = '0;
			start_seen = 1'b0;
			awaited_words.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_JUMP_THRESHOLD: spike_threshold = cfg_data;
					REG_JUMP_RATIO: spike_ratio = cfg_data[RATIO_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (awaited_words.size() == 0) begin
					$error("result word with no frame outstanding");
					errors++;
				end else begin
					want = awaited_words.pop_front();
					if (position !== want.position) begin
						$error("position: expected %0d, got %0d", want.position, position);
						errors++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						errors++;
					end
					if (initial_position !== want.initial_position) begin
						$error("initial_position: expected %0d, got %0d",
							want.initial_position, initial_position);
						errors++;
					end
					if (initial_valid !== want.initial_valid) begin
						$error("initial_valid: expected %0d, got %0d",
							want.initial_valid, initial_valid);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				awaited_words.push_back(filter_frame(frame_byte0, frame_byte1,
					frame_byte2, frame_byte3));
			end
			pending <= awaited_words.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// Drives encoder frames and register writes into the spike filter and reports the verdict.
module tb_top;
	import afsf_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	cfg_reg_t             cfg_index = REG_JUMP_THRESHOLD;
	logic [COUNT_W-1:0]   cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [BYTE_W-1:0]    frame_byte0 = '0;
	logic [BYTE_W-1:0]    frame_byte1 = '0;
	logic [BYTE_W-1:0]    frame_byte2 = '0;
	logic [BYTE_W-1:0]    frame_byte3 = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [COUNT_W-1:0]   position;
	status_t              status;
	logic [COUNT_W-1:0]   initial_position;
	logic                 initial_valid;
	int                   errors;
	int                   pending;

	int                   idle_pct = 0;
	int                   stall_pct = 0;
	logic                 hold_req = 1'b0;
	logic [COUNT_W-1:0]   walk = '0;
	int                   swing = 20;

	abs_encoder_frame_spike_filter uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.frame_byte0(frame_byte0),
		.frame_byte1(frame_byte1),
		.frame_byte2(frame_byte2),
		.frame_byte3(frame_byte3),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.position(position),
		.status(status),
		.initial_position(initial_position),
		.initial_valid(initial_valid)
	);

	afsf_frame_monitor mon (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.frame_byte0(frame_byte0),
		.frame_byte1(frame_byte1),
		.frame_byte2(frame_byte2),
		.frame_byte3(frame_byte3),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.position(position),
		.status(status),
		.initial_position(initial_position),
		.initial_valid(initial_valid),
		.errors(errors),
		.pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#2400000;
		$display("DONE: errors detected");
		$finish;
	end

	// Hold off the output for a long stretch on request, otherwise stall at random.
	initial begin
		int   hold_left;
		logic hold_ack;
		hold_left = 0;
		hold_ack = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				hold_left = 300;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	task automatic send_frame(input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1,
		input logic [BYTE_W-1:0] b2, input logic [BYTE_W-1:0] b3);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		frame_byte0 <= b0;
		frame_byte1 <= b1;
		frame_byte2 <= b2;
		frame_byte3 <= b3;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_count(input logic [COUNT_W-1:0] c);
		send_frame({1'($urandom), c[15:9]}, c[8:1], {c[0], 6'($urandom), 1'b0}, 8'h00);
	endtask

	task automatic send_random_frame();
		int                 pick;
		int                 delta;
		logic [BYTE_W-1:0]  r0;
		logic [BYTE_W-1:0]  r1;
		logic [BYTE_W-1:0]  r2;
		logic [BYTE_W-1:0]  r3;
		pick = $urandom_range(99);
		r0 = 8'($urandom);
		r1 = 8'($urandom);
		r2 = 8'($urandom);
		r3 = 8'($urandom);
		if ($urandom_range(39) == 0) begin
			case ($urandom_range(4))
				0: swing = 0;
				1: swing = 20;
				2: swing = 300;
				3: swing = 3000;
				default: swing = 40000;
			endcase
		end
		if (pick < 10) begin
			if ({r2[0], r3} == 9'd0) begin
				r3[3'($urandom_range(7))] = 1'b1;
			end
			send_frame(r0, r1, r2, r3);
		end else if (pick < 18) begin
			send_frame(r0, r1, r2, r3);
		end else if (pick < 28) begin
			send_count(walk + 16'($urandom_range(65535)));
		end else begin
			delta = $urandom_range(2 * swing) - swing;
			walk = walk + delta[COUNT_W-1:0];
			send_count(walk);
		end
	endtask

	task automatic write_config(input logic [COUNT_W-1:0] threshold,
		input logic [COUNT_W-1:0] ratio_word);
		cfg_valid <= 1'b1;
		cfg_index <= REG_JUMP_THRESHOLD;
		cfg_data <= threshold;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_JUMP_RATIO;
		cfg_data <= ratio_word;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int phase;
		int k;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_frame(8'hFF, 8'hFF, 8'h81, 8'h00);
		send_frame(8'h00, 8'h00, 8'h00, 8'h80);
		send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_count(16'h0000);
		send_frame(8'hFF, 8'hFF, 8'h80, 8'h00);
		send_frame(8'h80, 8'h00, 8'h7E, 8'h00);
		send_count(16'h0000);
		send_count(16'h8000);
		send_count(16'd50);
		send_count(16'd1000);
		send_frame(8'h00, 8'h00, 8'h00, 8'hFF);
		send_count(16'd100);
		send_count(16'h7FFF);
		send_count(16'hFFFF);
		send_count(16'd150);
		send_count(16'd300);
		settle();
		write_config(16'd0, 16'd0);
		send_count(16'd301);
		send_count(16'd450);
		send_count(16'd451);

		for (phase = 0; phase < 8; phase++) begin
			settle();
			case (phase)
				0: write_config(16'd0, 16'd1);
				1: write_config(16'hFFFF, 16'd15);
				2: write_config(16'd30, 16'd2);
				3: write_config(16'($urandom_range(3000)), 16'($urandom_range(15, 1)));
				4: write_config(16'd200, 16'd0);
				default: write_config(16'($urandom_range(1000)),
					{12'($urandom), 4'($urandom)});
			endcase
			case (phase % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 47;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 47;
				end
				default: begin
					idle_pct = 17;
					stall_pct = 17;
				end
			endcase
			if (phase == 4) begin
				hold_req = ~hold_req;
			end
			for (k = 0; k < 175; k++) begin
				send_random_frame();
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
